// ----- src/fekset_pkg.sv -----
// shared types and constants for the fifo evicting key set
package fekset_pkg;

  localparam int KEY_W = 64;
  localparam int OCC_W = 8;
  localparam int CAP_W = 8;
  localparam int MIN_CAPACITY = 8;
  localparam logic [CAP_W-1:0] RESET_CAPACITY = 8'd96;

  typedef enum logic [1:0] {
    KIND_QUERY    = 2'd0,
    KIND_REMEMBER = 2'd1,
    KIND_CLEAR    = 2'd2,
    KIND_NONE     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_RESOLVE
  } state_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

endpackage

// ----- src/fekset_cell.sv -----
// one slot of the key chain: held key, valid flag and registered match
module fekset_cell #(
  parameter int INDEX = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  fekset_pkg::cell_ctl_t         ctl,
  input  logic [fekset_pkg::CAP_W-1:0]  eff_cap,
  input  logic [fekset_pkg::KEY_W-1:0]  item_key,
  input  logic [fekset_pkg::KEY_W-1:0]  prev_key,
  input  logic                          prev_valid,
  output logic [fekset_pkg::KEY_W-1:0]  key_q,
  output logic                          valid_q,
  output logic                          match
);
  import fekset_pkg::*;

  logic in_limit;

  assign in_limit = INDEX < int'(eff_cap);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
      match   <= 1'b0;
    end else begin
      match <= valid_q && in_limit && (key_q == item_key);
      if (ctl.clear) begin
        valid_q <= 1'b0;
      end else if (ctl.shift) begin
        valid_q <= prev_valid && in_limit;
      end else begin
        valid_q <= valid_q && in_limit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      key_q <= prev_key;
    end
  end

endmodule

// ----- src/fekset_ctrl.sv -----
// request sequencing, capacity register and occupancy count
module fekset_ctrl #(
  parameter int MAX_ENTRIES = 128
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [1:0]                    kind,
  input  logic                          cfg_we,
  input  logic [fekset_pkg::CAP_W-1:0]  cfg_data,
  input  logic                          any_match,
  output logic                          busy,
  output logic                          accept,
  output fekset_pkg::cell_ctl_t         ctl,
  output logic [fekset_pkg::CAP_W-1:0]  eff_cap,
  output logic                          done,
  output logic                          hit,
  output logic [fekset_pkg::OCC_W-1:0]  occupancy
);
  import fekset_pkg::*;

  state_t state, state_next;
  kind_t kind_q;
  logic resolve;
  logic [OCC_W-1:0] count;
  logic [CAP_W-1:0] cfg_cap;

  function automatic logic [CAP_W-1:0] clamp_cap(input logic [CAP_W-1:0] v);
    logic [CAP_W-1:0] c;
    c = v;
    if (int'(v) < MIN_CAPACITY) begin
      c = CAP_W'(MIN_CAPACITY);
    end else if (int'(v) > MAX_ENTRIES) begin
      c = CAP_W'(MAX_ENTRIES);
    end
    return c;
  endfunction

  assign cfg_cap = clamp_cap(cfg_data);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    state_next = accept ? ST_MATCH : ST_IDLE;
      ST_MATCH:   state_next = ST_RESOLVE;
      ST_RESOLVE: state_next = accept ? ST_MATCH : ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state == ST_MATCH);
    accept    = start && !busy;
    resolve   = (state == ST_RESOLVE);
    ctl.clear = resolve && (kind_q == KIND_CLEAR);
    ctl.shift = resolve && (kind_q == KIND_REMEMBER) && !any_match;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      eff_cap <= clamp_cap(RESET_CAPACITY);
      count   <= '0;
      done    <= 1'b0;
      hit     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= resolve;
      hit   <= resolve && any_match
               && (kind_q == KIND_QUERY || kind_q == KIND_REMEMBER);
      if (cfg_we) begin
        eff_cap <= cfg_cap;
        if (count > cfg_cap) begin
          count <= cfg_cap;
        end
      end else if (ctl.clear) begin
        count <= '0;
      end else if (ctl.shift) begin
        count <= (count < eff_cap) ? OCC_W'(count + 1'b1) : eff_cap;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q <= kind_t'(kind);
    end
  end

  assign occupancy = count;

endmodule

// ----- src/fifo_evicting_key_set.sv -----
// top level: bounded recent-key set built as a shifting chain of key cells
//
// A request is taken when start is high and busy is low. Its result appears on hit and
// occupancy for one cycle with done high, registered at the end of the RESOLVE state; the
// receiver cannot stall it. busy is high only in the cycle after a request (state MATCH), so
// a new request can be taken while the previous one is in RESOLVE but not while it is in
// MATCH. In MATCH every cell compares its key against the request key and registers the
// match; RESOLVE reduces the matches and shifts or clears the chain. The newest key enters
// cell 0; keys at or past the capacity drop out at once.
// Capacity writes (cfg_we, cfg_data) take effect on the next cycle and trim the count.
module fifo_evicting_key_set #(
  parameter int MAX_ENTRIES = 128
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    kind,
  input  logic [fekset_pkg::KEY_W-1:0]  key,
  input  logic                          cfg_we,
  input  logic [fekset_pkg::CAP_W-1:0]  cfg_data,
  output logic                          done,
  output logic                          hit,
  output logic [fekset_pkg::OCC_W-1:0]  occupancy
);
  import fekset_pkg::*;

  logic accept;
  cell_ctl_t ctl;
  logic [CAP_W-1:0] eff_cap;
  logic [KEY_W-1:0] item_key;
  logic [KEY_W-1:0] chain_key [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] chain_valid;
  logic [MAX_ENTRIES-1:0] match_vec;
  logic any_match;

  always_ff @(posedge clk) begin
    if (accept) begin
      item_key <= key;
    end
  end

  assign any_match = |match_vec;

  fekset_ctrl #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .kind      (kind),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .any_match (any_match),
    .busy      (busy),
    .accept    (accept),
    .ctl       (ctl),
    .eff_cap   (eff_cap),
    .done      (done),
    .hit       (hit),
    .occupancy (occupancy)
  );

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_head
      fekset_cell #(
        .INDEX(i)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (ctl),
        .eff_cap    (eff_cap),
        .item_key   (item_key),
        .prev_key   (item_key),
        .prev_valid (1'b1),
        .key_q      (chain_key[i]),
        .valid_q    (chain_valid[i]),
        .match      (match_vec[i])
      );
    end else begin : g_body
      fekset_cell #(
        .INDEX(i)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (ctl),
        .eff_cap    (eff_cap),
        .item_key   (item_key),
        .prev_key   (chain_key[i-1]),
        .prev_valid (chain_valid[i-1]),
        .key_q      (chain_key[i]),
        .valid_q    (chain_valid[i]),
        .match      (match_vec[i])
      );
    end
  end

endmodule

// ----- src/fekset_checker.sv -----
// port-level checks on request timing and results, bound to the top level
module fekset_port_checks (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic [1:0]                    kind,
  input logic                          done,
  input logic                          hit,
  input logic [fekset_pkg::OCC_W-1:0]  occupancy
);
  import fekset_pkg::*;

  logic req;
  assign req = start && !busy;

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req |=> busy)
    else $error("busy not raised after request");

  a_busy_one_cycle: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("busy held more than one cycle");

  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    req |-> ##3 done)
    else $error("result not strobed three cycles after request");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobed on consecutive cycles");

  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    (req && kind == KIND_CLEAR) |-> ##3 (!hit && occupancy == '0))
    else $error("clear request did not empty the set");

endmodule

bind fifo_evicting_key_set fekset_port_checks u_fekset_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .kind      (kind),
  .done      (done),
  .hit       (hit),
  .occupancy (occupancy)
);

// ----- verif/fekset_checker.sv -----
// checker for the fifo evicting key set: tracks held keys and compares each hit and occupancy
module fekset_checker #(
  parameter int MAX_ENTRIES = 128
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic [1:0]                    kind,
  input  logic [fekset_pkg::KEY_W-1:0]  key,
  input  logic                          cfg_we,
  input  logic [fekset_pkg::CAP_W-1:0]  cfg_data,
  input  logic                          done,
  input  logic                          hit,
  input  logic [fekset_pkg::OCC_W-1:0]  occupancy,
  output int                            fail_count,
  output int                            waiting
);
  timeunit 1ns;
  timeprecision 1ps;
  import fekset_pkg::*;

  typedef struct packed {
    logic             hit;
    logic [OCC_W-1:0] occupancy;
  } lookup_result_t;

  lookup_result_t   expected_lookups[$];
  logic [KEY_W-1:0] recent_keys[$];
  logic [CAP_W-1:0] capacity = RESET_CAPACITY;

  initial begin
    fail_count = 0;
    waiting = 0;
  end

  function automatic int effective_capacity(logic [CAP_W-1:0] c);
    if (c < MIN_CAPACITY) return MIN_CAPACITY;
    if (c > MAX_ENTRIES) return MAX_ENTRIES;
    return int'(c);
  endfunction

  function automatic void trim_keys(int limit);
    while (recent_keys.size() > limit) void'(recent_keys.pop_front());
  endfunction

  function automatic logic key_held(logic [KEY_W-1:0] k);
    foreach (recent_keys[i]) begin
      if (recent_keys[i] == k) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic lookup_result_t lookup_and_update(kind_t op, logic [KEY_W-1:0] k);
    lookup_result_t r;
    r.hit = 1'b0;
    case (op)
      KIND_QUERY: r.hit = key_held(k);
      KIND_REMEMBER: begin
        r.hit = key_held(k);
        if (!r.hit) begin
          trim_keys(effective_capacity(capacity) - 1);
          recent_keys.insert(recent_keys.size(), k);
        end
      end
      KIND_CLEAR: recent_keys.delete();
      default: ;
    endcase
    r.occupancy = OCC_W'(recent_keys.size());
    return r;
  endfunction

  always @(posedge clk) begin
    lookup_result_t want;
    if (rst) begin
      recent_keys.delete();
      expected_lookups.delete();
      capacity = RESET_CAPACITY;
    end else begin
      if (done) begin
        if (expected_lookups.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result with no request outstanding: hit %0b occupancy %0d",
                     $time, hit, occupancy);
        end else begin
          want = expected_lookups.pop_front();
          if (hit !== want.hit || occupancy !== want.occupancy) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch: expected hit %0b occupancy %0d, got hit %0b occupancy %0d",
                       $time, want.hit, want.occupancy, hit, occupancy);
          end
        end
      end
      if (cfg_we) begin
        capacity = cfg_data;
        trim_keys(effective_capacity(capacity));
      end
      if (start && !busy) begin
        want = lookup_and_update(kind_t'(kind), key);
        expected_lookups.insert(expected_lookups.size(), want);
      end
    end
    waiting = expected_lookups.size();
  end

endmodule

// ----- verif/testbench.sv -----
// testbench top: drives requests and capacity writes into the key set and reports the verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import fekset_pkg::*;

  localparam int MAX_ENTRIES = 128;
  localparam int PHASE_ITEMS = 100;
  localparam int CYCLE_LIMIT = 200000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic [1:0]       kind = KIND_QUERY;
  logic [KEY_W-1:0] key = '0;
  logic             cfg_we = 1'b0;
  logic [CAP_W-1:0] cfg_data = '0;
  logic             busy;
  logic             done;
  logic             hit;
  logic [OCC_W-1:0] occupancy;
  int               fail_count;
  int               waiting;
  int unsigned      cycles = 0;

  fifo_evicting_key_set #(.MAX_ENTRIES(MAX_ENTRIES)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind), .key(key),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .done(done), .hit(hit), .occupancy(occupancy)
  );

  fekset_checker #(.MAX_ENTRIES(MAX_ENTRIES)) checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind), .key(key),
    .cfg_we(cfg_we), .cfg_data(cfg_data), .done(done), .hit(hit), .occupancy(occupancy),
    .fail_count(fail_count), .waiting(waiting)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // hold the request until an edge with busy low takes it
  task automatic send_request(input kind_t op, input logic [KEY_W-1:0] k);
    logic taken;
    taken = 1'b0;
    start <= 1'b1;
    kind <= op;
    key <= k;
    while (!taken) begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end
  endtask

  task automatic wait_quiet();
    start <= 1'b0;
    do @(negedge clk); while (waiting != 0);
    @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] c);
    cfg_we <= 1'b1;
    cfg_data <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [CAP_W-1:0] phase_caps [12];
    logic [KEY_W-1:0] pool[$];
    logic [KEY_W-1:0] k;
    kind_t            op;
    int               sent, burst, gap, remember_permil, r;

    phase_caps = '{8'd96, 8'd255, 8'd9, 8'd128, 8'd7, 8'd200,
                   8'd64, 8'd129, 8'd8, 8'd0, 8'd0, 8'd0};
    phase_caps[10] = CAP_W'($urandom_range(0, 255));
    phase_caps[11] = CAP_W'($urandom_range(0, 255));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_request(KIND_QUERY, '0);
    send_request(KIND_REMEMBER, '0);
    send_request(KIND_REMEMBER, '1);
    send_request(KIND_REMEMBER, '0);
    send_request(KIND_QUERY, '1);
    send_request(KIND_QUERY, 64'h8000_0000_0000_0000);
    send_request(KIND_NONE, '1);
    send_request(KIND_CLEAR, '1);
    send_request(KIND_QUERY, '0);
    send_request(KIND_QUERY, '1);
    wait_quiet();
    write_capacity('0);
    for (int i = 0; i < 10; i++) send_request(KIND_REMEMBER, 64'h1 << (6 * i));
    send_request(KIND_QUERY, 64'h1);
    send_request(KIND_QUERY, 64'h1 << 54);
    send_request(KIND_REMEMBER, 64'h1);
    wait_quiet();

    foreach (phase_caps[p]) begin
      write_capacity(phase_caps[p]);
      pool.delete();
      repeat ($urandom_range(4, 200)) begin
        k = {$urandom, $urandom};
        pool.insert(pool.size(), k);
      end
      remember_permil = $urandom_range(400, 850);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        burst = $urandom_range(1, 24);
        for (int b = 0; b < burst && sent < PHASE_ITEMS; b++) begin
          r = $urandom_range(0, 999);
          if (r < remember_permil) op = KIND_REMEMBER;
          else if (r < 985) op = KIND_QUERY;
          else if (r < 993) op = KIND_NONE;
          else op = KIND_CLEAR;
          r = $urandom_range(0, 99);
          if (r < 80) k = pool[$urandom_range(0, pool.size() - 1)];
          else if (r < 95) k = {$urandom, $urandom};
          else if (r < 97) k = '0;
          else if (r < 99) k = '1;
          else k = 64'h8000_0000_0000_0000;
          send_request(op, k);
          sent++;
        end
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      wait_quiet();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0 && waiting == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
